// ===== rtl/cuf_pkg.sv =====
`default_nettype none

package cuf_pkg;

   localparam int FRAME_BYTES = 9;
   localparam int BODY_BYTES = FRAME_BYTES - 2;
   localparam int BEAT_W = $clog2(FRAME_BYTES);
   localparam int BODY_W = $clog2(BODY_BYTES);
   localparam int QUEUE_DEPTH = 4;

   localparam logic FUNC_CMD = 1'b0;
   localparam logic FUNC_RX = 1'b1;

   localparam logic KIND_TX = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [2:0] CMD_READ = 3'd0;
   localparam logic [2:0] CMD_ZERO = 3'd1;
   localparam logic [2:0] CMD_SPAN = 3'd2;
   localparam logic [2:0] CMD_AUTO = 3'd3;
   localparam logic [2:0] CMD_RANGE = 3'd4;

   localparam logic [7:0] START_BYTE = 8'hFF;
   localparam logic [7:0] SENSOR_ADDR = 8'h01;
   localparam logic [7:0] OP_READ = 8'h86;
   localparam logic [7:0] OP_ZERO = 8'h87;
   localparam logic [7:0] OP_SPAN = 8'h88;
   localparam logic [7:0] OP_AUTO = 8'h79;
   localparam logic [7:0] OP_RANGE = 8'h99;
   localparam logic [7:0] AUTO_ON = 8'hA0;

   localparam logic [15:0] SPAN_LOW = 16'd1000;
   localparam logic [15:0] SPAN_HIGH = 16'd2000;
   localparam logic [15:0] RANGE_LOW = 16'd2000;
   localparam logic [15:0] RANGE_HIGH = 16'd5000;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_BAD_HEADER = 2'd1;
   localparam logic [1:0] ST_BAD_SUM = 2'd2;
   localparam logic [1:0] ST_BAD_ARG = 2'd3;

   typedef struct packed {
      logic        func;
      logic [2:0]  command;
      logic [15:0] argument;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last;
      logic [15:0] ppm;
      logic [1:0]  status;
   } rsp_type;

   // body holds frame bytes 2 through 8 of a command frame
   typedef struct packed {
      logic                        is_report;
      logic [BODY_BYTES-1:0][7:0]  body;
      logic [15:0]                 ppm;
      logic [1:0]                  status;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/cuf_front.sv =====
`default_nettype none

module cuf_front
   import cuf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      accept,
   input  wire req_type   req_data,
   output logic           ent_valid,
   output entry_type      ent
);

   localparam logic [BEAT_W-1:0] LAST_POS = BEAT_W'(FRAME_BYTES - 1);

   logic [BEAT_W-1:0] pos_ff, pos_in;
   logic [7:0]        sum_ff, sum_in;
   logic              hg_ff, hg_in;
   logic [7:0]        vh_ff, vh_in;
   logic [7:0]        vl_ff, vl_in;

   entry_type cmd_ent;
   entry_type rx_ent;
   logic      cmd_ok;
   logic [7:0] csum;

   always_comb begin
      cmd_ent = '0;
      cmd_ok = 1'b1;
      case (req_data.command)
         CMD_READ: begin
            cmd_ent.body[0] = OP_READ;
         end
         CMD_ZERO: begin
            cmd_ent.body[0] = OP_ZERO;
         end
         CMD_SPAN: begin
            cmd_ent.body[0] = OP_SPAN;
            cmd_ent.body[1] = req_data.argument[15:8];
            cmd_ent.body[2] = req_data.argument[7:0];
            cmd_ok = (req_data.argument == SPAN_LOW) || (req_data.argument == SPAN_HIGH);
         end
         CMD_AUTO: begin
            cmd_ent.body[0] = OP_AUTO;
            cmd_ent.body[1] = (|req_data.argument) ? AUTO_ON : 8'h00;
         end
         CMD_RANGE: begin
            cmd_ent.body[0] = OP_RANGE;
            cmd_ent.body[4] = req_data.argument[15:8];
            cmd_ent.body[5] = req_data.argument[7:0];
            cmd_ok = (req_data.argument == RANGE_LOW) || (req_data.argument == RANGE_HIGH);
         end
         default: begin
            cmd_ok = 1'b0;
         end
      endcase
      csum = SENSOR_ADDR;
      for (int i = 0; i < BODY_BYTES - 1; i++) begin
         csum = csum + cmd_ent.body[i];
      end
      cmd_ent.body[BODY_BYTES-1] = 8'h00 - csum;
      if (!cmd_ok) begin
         cmd_ent = '0;
         cmd_ent.is_report = 1'b1;
         cmd_ent.status = ST_BAD_ARG;
      end
   end

   always_comb begin
      rx_ent = '0;
      rx_ent.is_report = 1'b1;
      if (!hg_ff) begin
         rx_ent.status = ST_BAD_HEADER;
      end else if (req_data.rx_byte != 8'(8'h00 - sum_ff)) begin
         rx_ent.status = ST_BAD_SUM;
      end else begin
         rx_ent.status = ST_OK;
         rx_ent.ppm = {vh_ff, vl_ff};
      end
   end

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      hg_in = hg_ff;
      vh_in = vh_ff;
      vl_in = vl_ff;
      if (accept && req_data.func == FUNC_RX) begin
         if (pos_ff == '0) begin
            if (req_data.rx_byte == START_BYTE) begin
               pos_in = BEAT_W'(1);
               sum_in = '0;
               hg_in = 1'b1;
            end
         end else if (pos_ff < LAST_POS) begin
            sum_in = sum_ff + req_data.rx_byte;
            if (pos_ff == BEAT_W'(1) && req_data.rx_byte != OP_READ) begin
               hg_in = 1'b0;
            end
            if (pos_ff == BEAT_W'(2)) begin
               vh_in = req_data.rx_byte;
            end
            if (pos_ff == BEAT_W'(3)) begin
               vl_in = req_data.rx_byte;
            end
            pos_in = pos_ff + BEAT_W'(1);
         end else begin
            pos_in = '0;
         end
      end
   end

   assign ent_valid = accept && (req_data.func == FUNC_CMD || pos_ff == LAST_POS);
   assign ent = (req_data.func == FUNC_CMD) ? cmd_ent : rx_ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
         hg_ff <= 1'b1;
         vh_ff <= '0;
         vl_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         hg_ff <= hg_in;
         vh_ff <= vh_in;
         vl_ff <= vl_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cuf_queue.sv =====
`default_nettype none

module cuf_queue
   import cuf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      wr,
   input  wire entry_type wr_data,
   input  wire logic      rd,
   output entry_type      rd_data,
   output logic           full,
   output logic           nonempty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == CNT_W'(DEPTH));
   assign nonempty = (cnt_ff != '0);
   assign rd_data = slot_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (wr) begin
         wp_in = (wp_ff == PTR_W'(DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
      end
      if (rd) begin
         rp_in = (rp_ff == PTR_W'(DEPTH - 1)) ? '0 : rp_ff + PTR_W'(1);
      end
      if (wr && !rd) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (rd && !wr) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         slot_ff[wp_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cuf_back.sv =====
`default_nettype none

module cuf_back
   import cuf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      q_nonempty,
   input  wire entry_type q_data,
   output logic           q_rd,
   output logic           empty,
   input  wire logic      pop,
   output rsp_type        rsp_data
);

   localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(FRAME_BYTES - 1);

   logic              ov_ff, ov_in;
   rsp_type           out_ff, out_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic              load;
   logic [BODY_W-1:0] body_idx;
   logic [BEAT_W-1:0] body_off;
   logic [7:0]        beat_byte;

   assign load = q_nonempty && (!ov_ff || pop);
   assign body_off = beat_ff - BEAT_W'(2);
   assign body_idx = body_off[BODY_W-1:0];

   always_comb begin
      case (beat_ff)
         BEAT_W'(0): beat_byte = START_BYTE;
         BEAT_W'(1): beat_byte = SENSOR_ADDR;
         default:    beat_byte = q_data.body[body_idx];
      endcase
   end

   always_comb begin
      ov_in = ov_ff;
      out_in = out_ff;
      beat_in = beat_ff;
      q_rd = 1'b0;
      if (pop && ov_ff) begin
         ov_in = 1'b0;
      end
      if (load) begin
         ov_in = 1'b1;
         out_in = '0;
         if (q_data.is_report) begin
            out_in.kind = KIND_REPORT;
            out_in.last = 1'b1;
            out_in.ppm = q_data.ppm;
            out_in.status = q_data.status;
            q_rd = 1'b1;
         end else begin
            out_in.kind = KIND_TX;
            out_in.tx_byte = beat_byte;
            out_in.last = (beat_ff == LAST_BEAT);
            if (beat_ff == LAST_BEAT) begin
               beat_in = '0;
               q_rd = 1'b1;
            end else begin
               beat_in = beat_ff + BEAT_W'(1);
            end
         end
      end
   end

   assign empty = !ov_ff;
   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
         beat_ff <= '0;
      end else begin
         ov_ff <= ov_in;
         beat_ff <= beat_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/co2_sensor_uart_frame_engine.sv =====
// Host side of the nine-byte CO2 sensor serial protocol. A command item expands into the
// nine transmit beats FF 01 op d3..d7 checksum (last set on the ninth), or one report with
// status 3 when the command code or span/range value is not allowed. Received bytes are
// hunted for a 0xFF start byte and collected into a frame; the ninth byte gives one report
// with ppm and status. An item is taken every cycle while the internal queue has room;
// a received byte that completes no frame gives no result. The result side delivers
// one beat per cycle while pop takes it, so sustained command throughput is set by the
// beat expander behind the queue. Results leave in item order. An accepted item passes
// through a queue slot and then the output register before its first beat is shown.
`default_nettype none

module co2_sensor_uart_frame_engine
   import cuf_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   logic      accept;
   logic      ent_valid;
   entry_type ent;
   entry_type q_data;
   logic      q_rd;
   logic      q_nonempty;

   assign accept = push && !full;

   cuf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .ent_valid (ent_valid),
      .ent       (ent)
   );

   cuf_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (ent_valid),
      .wr_data  (ent),
      .rd       (q_rd),
      .rd_data  (q_data),
      .full     (full),
      .nonempty (q_nonempty)
   );

   cuf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_nonempty (q_nonempty),
      .q_data     (q_data),
      .q_rd       (q_rd),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/cuf_checker.sv =====
`default_nettype none

module cuf_checker
   import cuf_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    empty,
   input wire logic    pop,
   input wire rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result waiting right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("waiting beat changed or dropped");

   a_report_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.kind == KIND_REPORT |-> rsp_data.last && rsp_data.tx_byte == 8'h00)
      else $error("report without last or with tx byte");

   a_report_ppm: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.kind == KIND_REPORT && rsp_data.status != ST_OK
      |-> rsp_data.ppm == 16'h0000)
      else $error("failed report carries ppm");

   a_tx_clean: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.kind == KIND_TX |-> rsp_data.ppm == 16'h0000 &&
      rsp_data.status == ST_OK)
      else $error("transmit beat carries report fields");

endmodule

bind co2_sensor_uart_frame_engine cuf_checker u_cuf_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

`default_nettype wire
